FILE: src/wdwr_pkg.sv
// Shared types and fixed field widths for the weighted draw block.
// No dependencies; used by wdwr_mod and the top level.
package wdwr_pkg;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 4;
  localparam int IN_VALUE_W  = 32;
  localparam int IN_WEIGHT_W = 16;
  localparam int RAND_W      = 32;
  localparam int OUT_VALUE_W = 32;
  localparam int REMAIN_W    = 5;
  localparam int COUNT_W     = 5;

  // in_tdata: entry_index, entry_value, entry_weight, rand_word (low to high)
  localparam int IN_IDX_LSB    = 0;
  localparam int IN_VAL_LSB    = IN_IDX_LSB + INDEX_W;
  localparam int IN_WGT_LSB    = IN_VAL_LSB + IN_VALUE_W;
  localparam int IN_RAND_LSB   = IN_WGT_LSB + IN_WEIGHT_W;
  localparam int IN_FIELDS_W   = IN_RAND_LSB + RAND_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // out_tdata: drawn_value, remaining (low to high)
  localparam int OUT_FIELDS_W  = OUT_VALUE_W + REMAIN_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_REFILL = 2'd1,
    ACT_DRAW   = 2'd2
  } wdwr_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_MOD,
    ST_PICK,
    ST_EMIT
  } wdwr_state_t;

endpackage

FILE: src/wdwr_mem.sv
// Master table storage: value and weight arrays, one write port and one
// read port with registered read data. Depends on nothing else.
module wdwr_mem #(
  parameter int DEPTH        = 16,
  parameter int VALUE_WIDTH  = 32,
  parameter int WEIGHT_WIDTH = 16,
  parameter int IDX_W        = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [VALUE_WIDTH-1:0]  wr_value,
  input  logic [WEIGHT_WIDTH-1:0] wr_weight,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [VALUE_WIDTH-1:0]  rd_value,
  output logic [WEIGHT_WIDTH-1:0] rd_weight
);

  logic [VALUE_WIDTH-1:0]  value_mem  [DEPTH];
  logic [WEIGHT_WIDTH-1:0] weight_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr]  <= wr_value;
      weight_mem[wr_addr] <= wr_weight;
    end
  end

  always_ff @(posedge clk) begin
    rd_value  <= value_mem[rd_addr];
    rd_weight <= weight_mem[rd_addr];
  end

endmodule

FILE: src/wdwr_mod.sv
// Bit-serial remainder unit: random word modulo pool weight total,
// one dividend bit per cycle. Uses wdwr_pkg for the dividend width.
module wdwr_mod #(
  parameter int SUM_W = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wdwr_pkg::RAND_W-1:0] dividend,
  input  logic [SUM_W-1:0]            divisor,
  output logic                        done,
  output logic [SUM_W-1:0]            rem
);

  localparam int CNT_W = $clog2(wdwr_pkg::RAND_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [SUM_W-1:0]            div_r, div_nxt;
  logic [SUM_W-1:0]            rem_r, rem_nxt;
  logic [wdwr_pkg::RAND_W-1:0] shf_r, shf_nxt;
  logic [SUM_W:0]              trial;

  // remainder stays below the divisor, so the shifted value fits in SUM_W+1
  assign trial = {rem_r, shf_r[wdwr_pkg::RAND_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(wdwr_pkg::RAND_W);
      div_nxt  = divisor;
      rem_nxt  = '0;
      shf_nxt  = dividend;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = SUM_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = SUM_W'(trial);
      end
      shf_nxt = shf_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: src/weighted_draw_without_replacement.sv
// Top level of the weighted draw block: control sequencer, pool mask and
// stream ports. Uses wdwr_pkg, wdwr_mem and wdwr_mod.
//
// Holds a table of DEPTH value/weight pairs and a pool of entries not yet
// drawn. Every input beat gives exactly one output beat. A load or refill
// goes from idle straight to the emit state; a draw runs one pass over the
// table memory to total the pool weight, a 32-step bit-serial remainder, and
// a second pass over the memory to find the pick, each pass bound by the
// single table read port. A draw on an empty pool also goes straight to emit.
// One item is in work at a time; the next input beat is taken as soon as the
// result sits in the output register. The user writes entry_count on the cfg
// port only while the block is idle; the block itself does not enforce it.
module weighted_draw_without_replacement #(
  parameter int DEPTH        = 16,
  parameter int VALUE_WIDTH  = 32,
  parameter int WEIGHT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index[3:0], entry_value[35:4], entry_weight[51:36], rand_word[83:52]
  input  logic [wdwr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [wdwr_pkg::ACTION_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // drawn_value[31:0], remaining[36:32]
  output logic [wdwr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wdwr_pkg::COUNT_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = WEIGHT_WIDTH + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  wdwr_pkg::wdwr_state_t  state_r, state_nxt;
  wdwr_pkg::wdwr_action_t in_action;

  logic                             in_fire, out_free;
  logic [wdwr_pkg::COUNT_W-1:0]     count_r;
  logic [DEPTH-1:0]                 pool_mask_r, pool_mask_nxt, fill_mask;
  logic [CNT_W-1:0]                 pool_cnt_r, pool_cnt_nxt, fill_n;
  logic [wdwr_pkg::RAND_W-1:0]      rand_r, rand_nxt;
  logic [IDX_W-1:0]                 addr_r, addr_nxt;
  logic                             issuing_r, issuing_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]                 rd_idx_r, rd_idx_nxt;
  logic [SUM_W-1:0]                 acc_r, acc_nxt, acc_add, acc_eff;
  logic [SUM_W-1:0]                 target_r, target_nxt;
  logic                             res_found_r, res_found_nxt;
  logic [wdwr_pkg::OUT_VALUE_W-1:0] res_value_r, res_value_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [wdwr_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                             out_found_r, out_found_nxt;

  logic                    hit_in_pool, scan_last, pick_hit;
  logic                    mem_we, mod_start, mod_done;
  logic [IDX_W-1:0]        mem_waddr;
  logic [VALUE_WIDTH-1:0]  rd_value;
  logic [WEIGHT_WIDTH-1:0] rd_weight;
  logic [SUM_W-1:0]        mod_rem;

  assign in_action = wdwr_pkg::wdwr_action_t'(in_tuser);
  assign in_tready = (state_r == wdwr_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= wdwr_pkg::COUNT_W'(16);
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  // refill size saturates at the table depth
  always_comb begin
    if (32'(count_r) > DEPTH) begin
      fill_n = CNT_W'(DEPTH);
    end else begin
      fill_n = CNT_W'(count_r);
    end
    for (int i = 0; i < DEPTH; i++) begin
      fill_mask[i] = (32'(i) < 32'(fill_n));
    end
  end

  assign mem_waddr = IDX_W'(in_tdata[wdwr_pkg::IN_IDX_LSB +: wdwr_pkg::INDEX_W]);

  wdwr_mem #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .WEIGHT_WIDTH(WEIGHT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_value (VALUE_WIDTH'(in_tdata[wdwr_pkg::IN_VAL_LSB +: wdwr_pkg::IN_VALUE_W])),
    .wr_weight(WEIGHT_WIDTH'(in_tdata[wdwr_pkg::IN_WGT_LSB +: wdwr_pkg::IN_WEIGHT_W])),
    .rd_addr  (addr_r),
    .rd_value (rd_value),
    .rd_weight(rd_weight)
  );

  // scan data arrives in the cycle after its address; rd_idx_r tags it
  assign hit_in_pool = rd_vld_r && pool_mask_r[rd_idx_r];
  assign acc_add     = acc_r + SUM_W'(rd_weight);
  assign acc_eff     = hit_in_pool ? acc_add : acc_r;
  assign scan_last   = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign pick_hit    = hit_in_pool && (acc_add > target_r);

  wdwr_mod #(
    .SUM_W(SUM_W)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(rand_r),
    .divisor (acc_eff),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wdwr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_action == wdwr_pkg::ACT_DRAW && pool_cnt_r != '0) begin
            state_nxt = wdwr_pkg::ST_TOTAL;
          end else begin
            state_nxt = wdwr_pkg::ST_EMIT;
          end
        end
      end
      wdwr_pkg::ST_TOTAL: begin
        if (scan_last) begin
          state_nxt = (acc_eff == '0) ? wdwr_pkg::ST_EMIT : wdwr_pkg::ST_MOD;
        end
      end
      wdwr_pkg::ST_MOD: begin
        if (mod_done) begin
          state_nxt = wdwr_pkg::ST_PICK;
        end
      end
      wdwr_pkg::ST_PICK: begin
        if (pick_hit || scan_last) begin
          state_nxt = wdwr_pkg::ST_EMIT;
        end
      end
      wdwr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = wdwr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wdwr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pool_mask_nxt = pool_mask_r;
    pool_cnt_nxt  = pool_cnt_r;
    rand_nxt      = rand_r;
    addr_nxt      = addr_r;
    issuing_nxt   = issuing_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = addr_r;
    acc_nxt       = acc_r;
    target_nxt    = target_r;
    res_found_nxt = res_found_r;
    res_value_nxt = res_value_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_found_nxt = out_found_r;
    mem_we        = 1'b0;
    mod_start     = 1'b0;

    // table read pointer, shared by both passes
    if (state_r == wdwr_pkg::ST_TOTAL || state_r == wdwr_pkg::ST_PICK) begin
      rd_vld_nxt = issuing_r;
      if (issuing_r) begin
        addr_nxt = addr_r + IDX_W'(1);
        if (addr_r == LAST_IDX) begin
          issuing_nxt = 1'b0;
        end
      end
    end

    unique case (state_r)
      wdwr_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_found_nxt = 1'b0;
          res_value_nxt = '0;
          rand_nxt      = in_tdata[wdwr_pkg::IN_RAND_LSB +: wdwr_pkg::RAND_W];
          unique case (in_action)
            wdwr_pkg::ACT_LOAD: begin
              mem_we = (32'(in_tdata[wdwr_pkg::IN_IDX_LSB +: wdwr_pkg::INDEX_W]) < DEPTH);
            end
            wdwr_pkg::ACT_REFILL: begin
              pool_mask_nxt = fill_mask;
              pool_cnt_nxt  = fill_n;
            end
            wdwr_pkg::ACT_DRAW: begin
              addr_nxt    = '0;
              issuing_nxt = (pool_cnt_r != '0);
              acc_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      wdwr_pkg::ST_TOTAL: begin
        acc_nxt   = acc_eff;
        mod_start = scan_last && (acc_eff != '0);
      end
      wdwr_pkg::ST_MOD: begin
        if (mod_done) begin
          target_nxt  = mod_rem;
          acc_nxt     = '0;
          addr_nxt    = '0;
          issuing_nxt = 1'b1;
        end
      end
      wdwr_pkg::ST_PICK: begin
        acc_nxt = acc_eff;
        if (pick_hit) begin
          res_found_nxt           = 1'b1;
          res_value_nxt           = wdwr_pkg::OUT_VALUE_W'(rd_value);
          pool_mask_nxt[rd_idx_r] = 1'b0;
          pool_cnt_nxt            = pool_cnt_r - CNT_W'(1);
          issuing_nxt             = 1'b0;
        end
      end
      wdwr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_data_nxt  = wdwr_pkg::OUT_TDATA_W'({wdwr_pkg::REMAIN_W'(pool_cnt_r),
                                                  res_value_r});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wdwr_pkg::ST_IDLE;
      pool_mask_r <= '0;
      pool_cnt_r  <= '0;
      issuing_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_mask_r <= pool_mask_nxt;
      pool_cnt_r  <= pool_cnt_nxt;
      issuing_r   <= issuing_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rand_r      <= rand_nxt;
    addr_r      <= addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    acc_r       <= acc_nxt;
    target_r    <= target_nxt;
    res_found_r <= res_found_nxt;
    res_value_r <= res_value_nxt;
    out_data_r  <= out_data_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

  // pool size counter tracks the mask
  a_pool_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(pool_mask_r) == int'(pool_cnt_r))
    else $error("pool count out of step with pool mask");

  // remainder result only lands while the sequencer waits for it
  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == wdwr_pkg::ST_MOD))
    else $error("remainder done outside of modulo state");

  // no table pass is left running once the block is back to idle
  a_scan_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wdwr_pkg::ST_IDLE) |-> !issuing_r)
    else $error("table scan still issuing in idle");

endmodule
